// File: sv/rrip_pkg.sv
// Package: shared constants, payload types and controller/datapath command types
package rrip_pkg;

    localparam int NUM_SETS_DEF      = 2048;
    localparam int NUM_WAYS_DEF      = 16;
    localparam int TABLE_ENTRIES_DEF = 16384;
    localparam int LEADER_STRIDE_DEF = 64;

    localparam logic [1:0]  RV_MAX       = 2'd3;
    localparam logic [3:0]  CONF_CEIL    = 4'd15;
    localparam logic [3:0]  CONF_RESET   = 4'd7;
    localparam logic [10:0] SEL_MAX      = 11'd1024;
    localparam logic [10:0] SEL_RESET    = 11'd512;
    localparam logic [10:0] THRESH_RESET = 11'd717;

    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    typedef struct packed {
        logic        func;
        logic [10:0] set_index;
        logic [4:0]  way;
        logic [13:0] pc_bits;
        logic        is_writeback;
        logic        hit;
        logic [9:0]  random_draw;
    } t_in_item;

    typedef struct packed {
        logic [4:0] victim_way;
        logic       bypassed;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch input item, launch memory reads
        logic execute;   // read data valid: decide and write back
        logic clear;     // clearing pass active
    } t_rrip_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clear_done;
    } t_rrip_sts;

    // insertion value by confidence class
    function automatic logic [1:0] class_value(input logic wb, input logic [3:0] c);
        logic [1:0] v;
        if (wb || c == 4'd0)      v = 2'd3;
        else if (c < 4'd5)        v = 2'd3;
        else if (c == 4'd15)      v = 2'd0;
        else if (c > 4'd9)        v = 2'd1;
        else                      v = 2'd2;
        return v;
    endfunction

endpackage

// File: sv/rrip_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module rrip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/rrip_dp.sv
// Datapath: line and table memories, victim search, update rules, duel selector
module rrip_dp #(
    parameter int NUM_SETS      = rrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS      = rrip_pkg::NUM_WAYS_DEF,
    parameter int TABLE_ENTRIES = rrip_pkg::TABLE_ENTRIES_DEF,
    parameter int LEADER_STRIDE = rrip_pkg::LEADER_STRIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrip_pkg::t_rrip_cmd i_cmd,
    output rrip_pkg::t_rrip_sts o_sts,
    input  rrip_pkg::t_in_item  i_item,
    input  logic [10:0]         i_thresh,
    output rrip_pkg::t_out_item o_res,
    output logic                o_res_valid
);
    localparam int SW = $clog2(NUM_SETS);
    localparam int TW = $clog2(TABLE_ENTRIES);
    localparam int WW = $clog2(NUM_WAYS + 1);
    localparam int LW = 2 * NUM_WAYS;
    localparam int CW = (SW > TW) ? SW : TW;
    // leader divisors and their reciprocals (exact for any SW-bit set)
    localparam int DA = LEADER_STRIDE;
    localparam int DB = LEADER_STRIDE + 1;
    localparam int PA = SW + $clog2(DA);
    localparam int PB = SW + $clog2(DB);
    localparam int MA = (2 ** PA + DA - 1) / DA;
    localparam int MB = (2 ** PB + DB - 1) / DB;
    localparam int PW = PB + SW + 2;

    rrip_pkg::t_in_item r_item;
    logic [CW:0]        r_clr;      // clearing pass counter
    logic [10:0]        r_sel;
    logic               r_lead_a, r_lead_b;

    // set index / table index of the captured item
    logic [SW-1:0] set_q;
    logic [TW-1:0] pc_q;
    assign set_q = SW'(r_item.set_index);
    assign pc_q  = TW'(r_item.pc_bits);

    // memory ports
    logic          line_we, conf_we;
    logic [SW-1:0] line_waddr, line_raddr;
    logic [LW-1:0] line_wdata, line_rdata;
    logic [TW-1:0] conf_waddr, conf_raddr;
    logic [4:0]    conf_wdata, conf_rdata;   // {reuse, confidence}

    rrip_ram #(.WIDTH(LW), .DEPTH(NUM_SETS)) u_line (
        .i_clk(i_clk), .i_we(line_we), .i_waddr(line_waddr), .i_wdata(line_wdata),
        .i_raddr(line_raddr), .o_rdata(line_rdata)
    );
    rrip_ram #(.WIDTH(5), .DEPTH(TABLE_ENTRIES)) u_conf (
        .i_clk(i_clk), .i_we(conf_we), .i_waddr(conf_waddr), .i_wdata(conf_wdata),
        .i_raddr(conf_raddr), .o_rdata(conf_rdata)
    );

    assign line_raddr = SW'(i_item.set_index);
    assign conf_raddr = TW'(i_item.pc_bits);

    // set kind of the incoming set: quotient by reciprocal multiply, registered at capture
    logic [PW-1:0] prod_a, prod_b;
    logic [SW-1:0] quo_a, quo_b;
    logic          n_lead_a, n_lead_b;
    always_comb begin
        prod_a   = PW'(line_raddr) * PW'(MA);
        prod_b   = PW'(line_raddr) * PW'(MB);
        quo_a    = SW'(prod_a >> PA);
        quo_b    = SW'(prod_b >> PB);
        n_lead_a = (PW'(quo_a) * PW'(DA)) == PW'(line_raddr);
        n_lead_b = (PW'(quo_b) * PW'(DB)) == PW'(line_raddr);
    end

    logic lead_a, lead_b, follower;
    assign lead_a   = r_lead_a;
    assign lead_b   = r_lead_b;
    assign follower = !lead_a && !lead_b;

    logic [3:0] c;
    logic       reuse;
    assign c     = conf_rdata[3:0];
    assign reuse = conf_rdata[4];

    // victim: max of line, age, first way at 3
    logic [1:0]    mx, age;
    logic [LW-1:0] aged;
    logic [WW-1:0] pick;
    logic          byp;
    always_comb begin
        mx = 2'd0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (line_rdata[2*w +: 2] > mx) mx = line_rdata[2*w +: 2];
        end
        age  = rrip_pkg::RV_MAX - mx;
        pick = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            aged[2*w +: 2] = line_rdata[2*w +: 2] + age;
            if (aged[2*w +: 2] == rrip_pkg::RV_MAX) pick = WW'(w);
        end
        byp = !r_item.is_writeback && follower &&
              ((c == 4'd0) || (c == 4'd1 && {1'b0, r_item.random_draw} < i_thresh));
    end

    // update value and write-back data
    logic [1:0]    ins;
    logic          upd_ok;
    logic [LW-1:0] upd_line;
    logic [10:0]   n_sel;
    always_comb begin
        upd_ok = 32'(r_item.way) < NUM_WAYS;
        if (r_item.hit)    ins = 2'd0;
        else if (lead_a)   ins = rrip_pkg::class_value(r_item.is_writeback, c);
        else if (lead_b)   ins = 2'd0;
        else if (r_sel > rrip_pkg::SEL_RESET)
                           ins = rrip_pkg::class_value(r_item.is_writeback, c);
        else               ins = 2'd0;
        upd_line = line_rdata;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (32'(r_item.way) == w) upd_line[2*w +: 2] = ins;
        end
        n_sel = r_sel;
        if (!r_item.hit && !r_item.is_writeback && reuse) begin
            if (lead_a && r_sel > 11'd0)                     n_sel = r_sel - 11'd1;
            else if (!lead_a && lead_b && r_sel < rrip_pkg::SEL_MAX) n_sel = r_sel + 11'd1;
        end
    end

    // write ports: clearing pass, victim, update
    always_comb begin
        line_we = 1'b0; conf_we = 1'b0;
        line_waddr = set_q; conf_waddr = pc_q;
        line_wdata = aged;  conf_wdata = conf_rdata;
        if (i_cmd.clear) begin
            line_we    = 32'(r_clr) < NUM_SETS;
            conf_we    = 32'(r_clr) < TABLE_ENTRIES;
            line_waddr = r_clr[SW-1:0];
            conf_waddr = r_clr[TW-1:0];
            line_wdata = {NUM_WAYS{rrip_pkg::RV_MAX}};
            conf_wdata = {1'b0, rrip_pkg::CONF_RESET};
        end else if (i_cmd.execute) begin
            if (r_item.func == rrip_pkg::FUNC_VICTIM) begin
                line_we = !byp;
                conf_we = !byp && c != 4'd0;
                conf_wdata = {reuse, c - 4'd1};
            end else if (upd_ok) begin
                line_we    = 1'b1;
                line_wdata = upd_line;
                conf_we    = r_item.hit;
                conf_wdata = {1'b1, (c < rrip_pkg::CONF_CEIL) ? c + 4'd1 : c};
            end
        end
    end

    assign o_sts.clear_done = 32'(r_clr) >= ((NUM_SETS > TABLE_ENTRIES) ? NUM_SETS : TABLE_ENTRIES) - 1;

    // registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_sel       <= rrip_pkg::SEL_RESET;
            o_res_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) r_clr <= r_clr + 1'b1;
            o_res_valid <= i_cmd.execute && r_item.func == rrip_pkg::FUNC_VICTIM;
            if (i_cmd.execute && r_item.func == rrip_pkg::FUNC_UPDATE && upd_ok) r_sel <= n_sel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item   <= i_item;
            r_lead_a <= n_lead_a;
            r_lead_b <= n_lead_b;
        end
        if (i_cmd.execute) begin
            o_res.bypassed   <= byp;
            o_res.victim_way <= byp ? 5'(NUM_WAYS) : 5'(pick);
        end
    end

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel <= rrip_pkg::SEL_MAX) else $error("selector out of range");
    a_sel_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.execute) |-> $stable(r_sel) || $past(!i_rst_n))
        else $error("selector moved without update");
    a_no_we_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |-> !i_cmd.execute) else $error("execute during clear");
endmodule

// File: sv/rrip_ctrl.sv
// Controller: clearing pass after reset, capture/execute sequencing, output hold
module rrip_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_res_valid,
    input  logic                i_out_stall,
    output logic                o_valid,
    input  rrip_pkg::t_rrip_sts i_sts,
    output rrip_pkg::t_rrip_cmd o_cmd
);
    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_HOLD} t_state;
    t_state r_state, n_state;
    logic   r_valid;

    logic take;
    assign o_stall = r_state != S_IDLE;
    assign take    = i_valid && r_state == S_IDLE;
    assign o_valid = r_valid;

    always_comb begin
        o_cmd.clear   = r_state == S_CLEAR;
        o_cmd.capture = take;
        o_cmd.execute = r_state == S_EXEC;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clear_done) n_state = S_IDLE;
            S_IDLE:  if (take) n_state = S_EXEC;
            S_EXEC:  n_state = S_HOLD;
            S_HOLD: begin
                if (!i_res_valid && (!r_valid || !i_out_stall)) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // hold state: result lands in S_HOLD cycle, leave once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_res_valid)       r_valid <= 1'b1;
            else if (!i_out_stall) r_valid <= 1'b0;
        end
    end

    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> r_state == S_EXEC) else $error("capture not followed by execute");
    a_one_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> !r_valid || !i_out_stall) else $error("result overrun");
    a_no_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear |-> !o_cmd.capture) else $error("capture during clear");
endmodule

// File: sv/rrip_replacement_with_bypass_unit.sv
// Top level: RRIP replacement with set dueling and confidence bypass
//  channel | direction | handshake          | payload
//  in      | input     | i_valid / o_stall  | i_in  (t_in_item)
//  out     | output    | o_valid / i_stall  | o_out (t_out_item)
//  cfg     | input     | i_cfg_we           | i_cfg_wdata (bypass threshold)
// A victim request goes through capture with memory read, decide and write back,
// result register and result transfer; an update has no result to transfer. The
// steps are set by the read-modify-write of the line and table memories and by the
// wait for the result before the next capture. A stalled result holds the next item off.
// Reset starts a clearing pass over max(NUM_SETS, TABLE_ENTRIES) entries (16384 by
// default) during which o_stall is high.
module rrip_replacement_with_bypass_unit #(
    parameter int NUM_SETS      = rrip_pkg::NUM_SETS_DEF,
    parameter int NUM_WAYS      = rrip_pkg::NUM_WAYS_DEF,
    parameter int TABLE_ENTRIES = rrip_pkg::TABLE_ENTRIES_DEF,
    parameter int LEADER_STRIDE = rrip_pkg::LEADER_STRIDE_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  rrip_pkg::t_in_item  i_in,
    output logic                o_valid,
    input  logic                i_stall,
    output rrip_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_wdata
);
    logic [10:0]         r_thresh;
    rrip_pkg::t_rrip_cmd cmd;
    rrip_pkg::t_rrip_sts sts;
    logic                res_valid;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_thresh <= rrip_pkg::THRESH_RESET;
        else if (i_cfg_we) r_thresh <= i_cfg_wdata;
    end

    rrip_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_res_valid(res_valid), .i_out_stall(i_stall), .o_valid(o_valid),
        .i_sts(sts), .o_cmd(cmd)
    );

    rrip_dp #(
        .NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS),
        .TABLE_ENTRIES(TABLE_ENTRIES), .LEADER_STRIDE(LEADER_STRIDE)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts), .i_item(i_in),
        .i_thresh(r_thresh), .o_res(o_out), .o_res_valid(res_valid)
    );
endmodule

// File: sim/rrip_replacement_with_bypass_unit_tb.sv
// Testbench for the RRIP replacement unit with set dueling and confidence bypass
`timescale 1ns / 100ps

module rrip_replacement_with_bypass_unit_tb;

    localparam int N_SETS   = rrip_pkg::NUM_SETS_DEF;
    localparam int N_WAYS   = rrip_pkg::NUM_WAYS_DEF;
    localparam int N_PC     = rrip_pkg::TABLE_ENTRIES_DEF;
    localparam int STRIDE   = rrip_pkg::LEADER_STRIDE_DEF;
    localparam int N_RANDOM = 1500;
    localparam int N_DIR    = 18;
    localparam int IN_BITS  = $bits(rrip_pkg::t_in_item);

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    rrip_pkg::t_in_item  i_in = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    rrip_pkg::t_out_item o_out;
    logic                i_cfg_we = 1'b0;
    logic [10:0]         i_cfg_wdata = '0;

    rrip_replacement_with_bypass_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_in(i_in),
        .o_valid(o_valid), .i_stall(i_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predictor state
    logic [1:0]  line_rv [N_SETS*N_WAYS];
    logic [3:0]  pc_conf [N_PC];
    logic        pc_reuse [N_PC];
    logic [10:0] selector;
    logic [10:0] threshold;

    rrip_pkg::t_out_item victim_q[$];
    int        errors = 0;
    bit        stim_done = 1'b0;
    bit        hold_long = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $time);
        errors++;
    endtask

    function automatic logic [1:0] insert_value(input bit wb, input logic [3:0] c);
        if (wb || c == 0 || c < 5) return 2'd3;
        if (c == 15) return 2'd0;
        if (c > 9) return 2'd1;
        return 2'd2;
    endfunction

    // apply one accepted item to the predictor; queue a victim if one results
    task automatic predict_replacement(input rrip_pkg::t_in_item it);
        int s, t, base, w, mx, pick;
        bit lead_a, lead_b, byp, found;
        logic [3:0] c;
        rrip_pkg::t_out_item r;
        s = it.set_index % N_SETS;
        t = it.pc_bits % N_PC;
        base = s * N_WAYS;
        lead_a = (s % STRIDE) == 0;
        lead_b = !lead_a && (s % (STRIDE + 1)) == 0;
        c = pc_conf[t];
        if (it.func == rrip_pkg::FUNC_VICTIM) begin
            byp = !it.is_writeback && !lead_a && !lead_b &&
                  (c == 0 || (c == 1 && it.random_draw < threshold));
            if (byp) begin
                r.victim_way = 5'(N_WAYS);
                r.bypassed = 1'b1;
            end else begin
                mx = 0;
                for (w = 0; w < N_WAYS; w++) if (line_rv[base+w] > mx) mx = line_rv[base+w];
                found = 0;
                pick = 0;
                for (w = 0; w < N_WAYS; w++) begin
                    line_rv[base+w] = line_rv[base+w] + 2'(3 - mx);
                    if (!found && line_rv[base+w] == rrip_pkg::RV_MAX) begin
                        pick = w;
                        found = 1;
                    end
                end
                if (c > 0) pc_conf[t] = c - 4'd1;
                r.victim_way = 5'(pick);
                r.bypassed = 1'b0;
            end
            victim_q.push_back(r);
        end else if (it.way < N_WAYS) begin
            if (it.hit) begin
                pc_reuse[t] = 1'b1;
                line_rv[base+it.way] = 2'd0;
                if (c < rrip_pkg::CONF_CEIL) pc_conf[t] = c + 4'd1;
            end else if (lead_a) begin
                if (!it.is_writeback && pc_reuse[t] && selector > 0) selector--;
                line_rv[base+it.way] = insert_value(it.is_writeback, c);
            end else if (lead_b) begin
                if (!it.is_writeback && pc_reuse[t] && selector < rrip_pkg::SEL_MAX)
                    selector++;
                line_rv[base+it.way] = 2'd0;
            end else if (selector > rrip_pkg::SEL_RESET) begin
                line_rv[base+it.way] = insert_value(it.is_writeback, c);
            end else begin
                line_rv[base+it.way] = 2'd0;
            end
        end
    endtask

    function automatic rrip_pkg::t_in_item make_item(input bit f, input int s, input int w,
                                                     input int pc, input bit wb, input bit h,
                                                     input int d);
        rrip_pkg::t_in_item it;
        it.func = f; it.set_index = 11'(s); it.way = 5'(w); it.pc_bits = 14'(pc);
        it.is_writeback = wb; it.hit = h; it.random_draw = 10'(d);
        return it;
    endfunction

    function automatic rrip_pkg::t_in_item noise_item();
        return rrip_pkg::t_in_item'(IN_BITS'({$urandom, $urandom}));
    endfunction

    // mostly small set / PC pools so that lines age and confidences move
    function automatic rrip_pkg::t_in_item rand_item();
        rrip_pkg::t_in_item it;
        int k;
        it = noise_item();
        k = $urandom_range(0, 9);
        if (k < 4) it.set_index = 11'($urandom_range(0, 3) * 64 + $urandom_range(0, 2));
        else if (k < 6) it.set_index = 11'($urandom_range(1, 31) * 65);
        if ($urandom_range(0, 9) < 8) it.pc_bits = 14'($urandom_range(0, 7) * 2049);
        if ($urandom_range(0, 9) < 8) it.way = 5'($urandom_range(0, 15));
        else it.way = 5'($urandom_range(16, 31));
        if ($urandom_range(0, 3) != 0) it.is_writeback = 1'b0;
        return it;
    endfunction

    rrip_pkg::t_in_item  dir_item [N_DIR];
    bit                  dir_has  [N_DIR];
    rrip_pkg::t_out_item dir_exp  [N_DIR];

    // directed table: extremes, writeback, ignored update, leaders
    initial begin
        for (int i = 0; i < N_DIR; i++) dir_has[i] = 0;
        dir_item[0]  = make_item(0, 0, 0, 0, 0, 0, 0);        // leader A: way 0
        dir_exp[0]   = '{victim_way: 5'd0, bypassed: 1'b0}; dir_has[0] = 1;
        dir_item[1]  = make_item(0, 2047, 0, 16383, 1, 1, 1023);
        dir_exp[1]   = '{victim_way: 5'd0, bypassed: 1'b0}; dir_has[1] = 1;
        dir_item[2]  = make_item(1, 5, 0, 100, 0, 1, 0);      // hit way 0
        dir_item[3]  = make_item(0, 5, 0, 100, 0, 0, 0);      // now way 1
        dir_exp[3]   = '{victim_way: 5'd1, bypassed: 1'b0}; dir_has[3] = 1;
        dir_item[4]  = make_item(1, 5, 31, 100, 0, 1, 0);     // ignored
        dir_item[5]  = make_item(1, 5, 16, 100, 0, 0, 0);     // ignored
        dir_item[6]  = make_item(1, 1, 15, 200, 0, 0, 0);
        dir_item[7]  = make_item(1, 65, 3, 200, 0, 1, 0);
        dir_item[8]  = make_item(1, 65, 4, 200, 0, 0, 0);     // leader B fill
        dir_item[9]  = make_item(1, 64, 4, 200, 1, 0, 0);     // leader A wb fill
        dir_item[10] = make_item(1, 64, 5, 200, 0, 0, 0);
        for (int i = 11; i < N_DIR; i++)                       // drive pc 300 down
            dir_item[i] = make_item(0, 7, 0, 300, 0, 0, 1023);
    end

    // sender
    task automatic send_item(input rrip_pkg::t_in_item it);
        i_valid <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (o_stall);
        predict_replacement(it);
        if ($urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            i_in <= noise_item();
            repeat ($urandom_range(0, 9) < 9 ? $urandom_range(1, 3) : $urandom_range(10, 40))
                @(posedge i_clk);
        end
    endtask

    task automatic idle_wait();
        i_valid <= 1'b0;
        while (victim_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [10:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        threshold = v;
    endtask

    initial begin
        logic [10:0] th_set [4];
        th_set = '{11'd0, 11'd2047, 11'd1024, 11'd500};
        for (int i = 0; i < N_SETS*N_WAYS; i++) line_rv[i] = rrip_pkg::RV_MAX;
        for (int i = 0; i < N_PC; i++) begin
            pc_conf[i] = rrip_pkg::CONF_RESET;
            pc_reuse[i] = 1'b0;
        end
        selector = rrip_pkg::SEL_RESET;
        threshold = rrip_pkg::THRESH_RESET;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // directed part at reset threshold
        for (int i = 0; i < N_DIR; i++) begin
            if (dir_has[i]) begin
                rrip_pkg::t_out_item pred;
                send_item(dir_item[i]);
                pred = victim_q[$];
                if (pred != dir_exp[i])
                    report_mismatch("directed table", int'(pred), int'(dir_exp[i]));
            end else begin
                send_item(dir_item[i]);
            end
        end
        // random phases across thresholds
        for (int ph = 0; ph < 5; ph++) begin
            idle_wait();
            if (ph > 0) write_threshold(th_set[ph-1]);
            if (ph == 2) hold_long = 1'b1;
            for (int i = 0; i < N_RANDOM / 5; i++) send_item(rand_item());
        end
        idle_wait();
        stim_done = 1'b1;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                hold_long = 1'b0;
                i_stall <= 1'b1;
                for (n = 0; n < 300; n++) @(posedge i_clk);
            end
            if ($urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(0, 9) < 9 ? $urandom_range(1, 3)
                                                 : $urandom_range(10, 40))
                    @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? 60 : $urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (victim_q.size() == 0) begin
                report_mismatch("unexpected result", int'(o_out), 0);
            end else begin
                rrip_pkg::t_out_item e;
                e = victim_q.pop_front();
                if (o_out.victim_way !== e.victim_way)
                    report_mismatch("victim_way", int'(o_out.victim_way), int'(e.victim_way));
                if (o_out.bypassed !== e.bypassed)
                    report_mismatch("bypassed", int'(o_out.bypassed), int'(e.bypassed));
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && victim_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // timeout
    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end
endmodule

// File: filelist.f
sv/rrip_pkg.sv
sv/rrip_ram.sv
sv/rrip_dp.sv
sv/rrip_ctrl.sv
sv/rrip_replacement_with_bypass_unit.sv
sim/rrip_replacement_with_bypass_unit_tb.sv
